[sv/assert_macros.svh]
// Assertion macros used by the top-level core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TBG_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
	else $error("assertion failed");
`define TBG_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define TBG_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TBG_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[sv/tbgeq_pkg.sv]
// Types, codes and saturation helpers of the graphic equalizer and limiter.
package tbgeq_pkg;
	localparam int BANDS_DEF   = 10;
	localparam int COEF_WORDS  = 6;
	localparam logic [1:0] CMD_SAMPLE = 2'd0;
	localparam logic [1:0] CMD_WRITE  = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;
	localparam logic [2:0] SEL_GAIN   = 3'd6;
	localparam logic [1:0] CFG_LIMIT_EN = 2'd0;
	localparam logic [1:0] CFG_DECAY    = 2'd1;
	localparam logic [1:0] CFG_TRIM     = 2'd2;
	localparam logic [31:0] DECAY_RST = 32'd4294006297;
	localparam logic [22:0] TRIM_RST  = 23'd7801405;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [23:0] sample;
		logic [3:0]         band;
		logic [2:0]         word_sel;
		logic signed [31:0] coef_value;
	} req_t;

	typedef struct packed {
		logic signed [23:0] out_sample;
		logic               trimmed;
	} rsp_t;

	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		logic signed [31:0] r;
		if (v[39:31] == {9{v[39]}})
			r = v[31:0];
		else
			r = v[39] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
		return r;
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
		logic signed [23:0] r;
		if (v[27:23] == {5{v[27]}})
			r = v[23:0];
		else
			r = v[27] ? {1'b1, 23'b0} : {1'b0, {23{1'b1}}};
		return r;
	endfunction
endpackage

[sv/tbgeq_if.sv]
// Handshake channels of the equalizer: sample/command requests, results, configuration.
interface tbgeq_req_if;
	logic              valid;
	logic              ready;
	tbgeq_pkg::req_t   payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface tbgeq_rsp_if;
	logic              valid;
	logic              ready;
	tbgeq_pkg::rsp_t   payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface tbgeq_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[sv/tbgeq_mul.sv]
// Shared signed multiplier with a registered product.
module tbgeq_mul (
	input  logic               clk,
	input  logic signed [32:0] a,
	input  logic signed [32:0] b,
	output logic signed [65:0] p_s1
);
	always_ff @(posedge clk) begin
		p_s1 <= a * b;
	end
endmodule

[sv/tbgeq_div.sv]
// Restoring divider, one quotient bit per cycle, 32-bit quotient.
module tbgeq_div (
	input  logic                clk,
	input  logic                arst_n,
	input  tbgeq_pkg::div_ctl_t ctl,
	input  logic [63:0]         dividend,
	input  logic [31:0]         divisor,
	output tbgeq_pkg::div_sts_t sts,
	output logic [31:0]         quot
);
	import tbgeq_pkg::*;

	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dsr_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] shifted;
	logic        fits;

	assign shifted = {rem_q, quo_q[31]};
	assign fits    = shifted >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= dividend[63:32];
			quo_q <= dividend[31:0];
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 32'(shifted - {1'b0, dsr_q}) : shifted[31:0];
			quo_q <= {quo_q[30:0], fits};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quot     = quo_q;
endmodule

[sv/ten_band_graphic_eq_limiter_core.sv]
// Top level: ten-band equalizer cascade and peak limiter on one shared multiplier.
//  channel | dir | payload                                   | transfer when
//  req     | in  | cmd, sample, band, word_sel, coef_value    | valid & ready
//  rsp     | out | out_sample, trimmed                       | valid & ready
//  cfg     | in  | index, data                               | valid & ready
// A sample passes RD0, RD1, RD2 per bypassed band plus M0, M1, M2, UPD per active band,
// then LIM, OUT without limiting, LIM, DEC, OUT with limiting below trim, and LIM, LMUL,
// DIV (on the 32-step divider), DEC, OUT when trimming. Writes and clears finish in IDLE.
// arst_n clears control, histories, gains, peak and coefficient valid bits.
// req.ready is low while a sample is in work; a result waits in the output register.
`include "assert_macros.svh"
module ten_band_graphic_eq_limiter_core #(
	parameter int BANDS = tbgeq_pkg::BANDS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	tbgeq_req_if.sink  req,
	tbgeq_rsp_if.source rsp,
	tbgeq_cfg_if.sink  cfg
);
	import tbgeq_pkg::*;

	localparam int BW    = (BANDS > 1) ? $clog2(BANDS) : 1;
	localparam int DEPTH = BANDS * COEF_WORDS;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RD0  = 4'd1;
	localparam logic [3:0] ST_RD1  = 4'd2;
	localparam logic [3:0] ST_RD2  = 4'd3;
	localparam logic [3:0] ST_M0   = 4'd4;
	localparam logic [3:0] ST_M1   = 4'd5;
	localparam logic [3:0] ST_M2   = 4'd6;
	localparam logic [3:0] ST_UPD  = 4'd7;
	localparam logic [3:0] ST_LIM  = 4'd8;
	localparam logic [3:0] ST_LMUL = 4'd9;
	localparam logic [3:0] ST_DIV  = 4'd10;
	localparam logic [3:0] ST_DEC  = 4'd11;
	localparam logic [3:0] ST_OUT  = 4'd12;

	logic [3:0]         state_q;
	logic [BW-1:0]      band_q;
	logic signed [31:0] v_q, a0_q, b1_q, b2_q;
	logic signed [39:0] acc_q;
	logic [31:0]        peak_q;
	logic               trim_flag_q;
	logic               neg_q;
	logic               limit_en_q;
	logic [31:0]        decay_q;
	logic [22:0]        trim_q;

	logic signed [31:0] gain_q [BANDS];
	logic signed [31:0] x1_q [BANDS];
	logic signed [31:0] x2_q [BANDS];
	logic signed [31:0] y1_q [BANDS];
	logic signed [31:0] y2_q [BANDS];

	logic signed [31:0] mem [DEPTH];
	logic [DEPTH-1:0]   vld_q;
	logic signed [31:0] rd_q;
	logic               rvld_q;
	logic signed [31:0] coef;

	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod;
	logic signed [65:0] prod_sh;
	logic signed [39:0] shr40;
	div_ctl_t           div_ctl;
	div_sts_t           div_sts;
	logic [31:0]        quot;
	logic [63:0]        div_num;

	logic               accept;
	logic               write_ok;
	logic [AW-1:0]      wr_addr, rd_addr;
	logic [BW-1:0]      wr_band;
	logic signed [31:0] cur_gain;
	logic               use_cut;
	logic signed [31:0] a0_new;
	logic signed [31:0] y_new;
	logic signed [31:0] v_new;
	logic [31:0]        mag;
	logic [31:0]        pk;
	logic [31:0]        trim32;
	logic               over;
	logic               last_band;
	logic signed [31:0] q_signed;

	tbgeq_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_s1(prod));

	tbgeq_div u_div (
		.clk(clk), .arst_n(arst_n), .ctl(div_ctl), .dividend(div_num),
		.divisor(peak_q), .sts(div_sts), .quot(quot)
	);

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.payload = rsp_q;

	assign write_ok = ({2'b0, req.payload.band} < 6'(BANDS));
	assign wr_band  = BW'(req.payload.band);
	assign wr_addr  = AW'(req.payload.band) * AW'(COEF_WORDS) + AW'(req.payload.word_sel);

	assign cur_gain = gain_q[band_q];
	assign use_cut  = !(cur_gain > 32'sd0);
	always_comb begin
		rd_addr = AW'(band_q) * AW'(COEF_WORDS) + (use_cut ? AW'(3) : AW'(0));
		case (state_q)
			ST_RD1:  rd_addr = rd_addr + AW'(1);
			ST_RD2:  rd_addr = rd_addr + AW'(2);
			default: rd_addr = rd_addr;
		endcase
	end

	assign coef      = rvld_q ? rd_q : 32'sd0;
	assign prod_sh   = prod >>> 28;
	assign shr40     = prod_sh[39:0];
	assign a0_new    = sat32(shr40);
	assign y_new     = sat32(acc_q + shr40);
	assign v_new     = sat32(40'(y_new) + 40'(v_q));
	assign mag       = v_q[31] ? 32'(-v_q) : 32'(v_q);
	assign pk        = (mag > peak_q) ? mag : peak_q;
	assign trim32    = {5'b0, trim_q, 4'b0};
	assign over      = pk > trim32;
	assign last_band = (band_q == BW'(BANDS - 1));
	assign div_num   = prod[65] ? 64'(-prod) : prod[63:0];
	assign q_signed  = neg_q ? -$signed(quot) : $signed(quot);
	assign div_ctl.start = (state_q == ST_LMUL);

	// Operand select for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_RD1: begin
				mul_a = 33'(coef);
				mul_b = 33'(cur_gain);
			end
			ST_M0: begin
				mul_a = 33'(v_q) - 33'(x2_q[band_q]);
				mul_b = 33'(a0_q);
			end
			ST_M1: begin
				mul_a = 33'(y1_q[band_q]);
				mul_b = 33'(b1_q);
			end
			ST_M2: begin
				mul_a = 33'(y2_q[band_q]);
				mul_b = 33'(b2_q);
			end
			ST_LIM: begin
				if (over) begin
					mul_a = 33'(v_q);
					mul_b = {5'b0, trim32[27:0]};
				end else begin
					mul_a = {1'b0, pk};
					mul_b = {1'b0, decay_q};
				end
			end
			ST_DIV: begin
				mul_a = {1'b0, peak_q};
				mul_b = {1'b0, decay_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && req.payload.cmd == CMD_WRITE && write_ok &&
		    req.payload.word_sel < SEL_GAIN)
			mem[wr_addr] <= req.payload.coef_value;
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_en_q <= 1'b0;
			decay_q    <= DECAY_RST;
			trim_q     <= TRIM_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_LIMIT_EN: limit_en_q <= cfg.data[0];
				CFG_DECAY:    decay_q    <= cfg.data;
				CFG_TRIM:     trim_q     <= cfg.data[22:0];
				default:      limit_en_q <= limit_en_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			band_q      <= '0;
			peak_q      <= '0;
			vld_q       <= '0;
			rvld_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
			trim_flag_q <= 1'b0;
			neg_q       <= 1'b0;
			v_q         <= '0;
			a0_q        <= '0;
			b1_q        <= '0;
			b2_q        <= '0;
			acc_q       <= '0;
			for (int i = 0; i < BANDS; i++) begin
				gain_q[i] <= '0;
				x1_q[i]   <= '0;
				x2_q[i]   <= '0;
				y1_q[i]   <= '0;
				y2_q[i]   <= '0;
			end
		end else begin
			rvld_q <= vld_q[rd_addr];
			if (rsp_valid_q && rsp.ready)
				rsp_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.payload.cmd)
							CMD_SAMPLE: begin
								v_q         <= 32'(req.payload.sample) <<< 4;
								band_q      <= '0;
								trim_flag_q <= 1'b0;
								state_q     <= ST_RD0;
							end
							CMD_WRITE: begin
								if (write_ok) begin
									if (req.payload.word_sel == SEL_GAIN)
										gain_q[wr_band] <= req.payload.coef_value;
									else if (req.payload.word_sel < SEL_GAIN)
										vld_q[wr_addr] <= 1'b1;
								end
							end
							CMD_CLEAR: begin
								peak_q <= '0;
								for (int i = 0; i < BANDS; i++) begin
									gain_q[i] <= '0;
									x1_q[i]   <= '0;
									x2_q[i]   <= '0;
									y1_q[i]   <= '0;
									y2_q[i]   <= '0;
								end
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_RD0: state_q <= ST_RD1;
				ST_RD1: state_q <= ST_RD2;
				ST_RD2: begin
					b1_q <= coef;
					a0_q <= a0_new;
					if (a0_new == 32'sd0) begin
						// bypass: history stays as is
						if (last_band) begin
							state_q <= ST_LIM;
						end else begin
							band_q  <= band_q + BW'(1);
							state_q <= ST_RD0;
						end
					end else begin
						state_q <= ST_M0;
					end
				end
				ST_M0: begin
					b2_q    <= coef;
					state_q <= ST_M1;
				end
				ST_M1: begin
					acc_q   <= shr40;
					state_q <= ST_M2;
				end
				ST_M2: begin
					acc_q   <= acc_q + shr40;
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					x2_q[band_q] <= x1_q[band_q];
					x1_q[band_q] <= v_q;
					y2_q[band_q] <= y1_q[band_q];
					y1_q[band_q] <= y_new;
					v_q          <= v_new;
					if (last_band) begin
						state_q <= ST_LIM;
					end else begin
						band_q  <= band_q + BW'(1);
						state_q <= ST_RD0;
					end
				end
				ST_LIM: begin
					if (!limit_en_q) begin
						state_q <= ST_OUT;
					end else begin
						peak_q  <= pk;
						state_q <= over ? ST_LMUL : ST_DEC;
					end
				end
				ST_LMUL: begin
					neg_q   <= prod[65];
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_sts.done) begin
						v_q         <= q_signed;
						trim_flag_q <= 1'b1;
						state_q     <= ST_DEC;
					end
				end
				ST_DEC: begin
					peak_q  <= prod[63:32];
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					// hold until the output register is free
					if (!rsp_valid_q || rsp.ready) begin
						rsp_q.out_sample <= sat24(v_q[31:4]);
						rsp_q.trimmed    <= trim_flag_q;
						rsp_valid_q      <= 1'b1;
						state_q          <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`TBG_ASSERT_IMP(a_div_live, clk, arst_n, state_q == ST_DIV, div_sts.busy || div_sts.done)
	`TBG_ASSERT_IMP(a_trim_en, clk, arst_n, rsp.valid && rsp.payload.trimmed, limit_en_q)
	`TBG_ASSERT_NXT(a_div_start, clk, arst_n, state_q == ST_LMUL, div_sts.busy)
endmodule
